@@ src/segment_hole_allocator_core_assert.svh @@
// Assertion macros for the segment hole allocator.
// Included by the top level, which checks its own logic; needs no package.
`ifndef SEGMENT_HOLE_ALLOCATOR_CORE_ASSERT_SVH
`define SEGMENT_HOLE_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SHAC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shac: assertion failed");
// Next-cycle implication, checked out of reset.
`define SHAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shac: assertion failed");
`else
`define SHAC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SHAC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/shac_pkg.sv @@
// Shared types and codes of the segment hole allocator.
// Used by the fit unit and the top level; depends on nothing.
package shac_pkg;

    // Fixed field widths
    localparam int ADDR_FIELD_W = 24;
    localparam int REQ_W        = 24;
    localparam int PID_W        = 16;
    localparam int SID_W        = 8;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;

    typedef logic [1:0] t_opcode;
    typedef logic [1:0] t_status;
    typedef logic [1:0] t_fit_mode;

    localparam t_opcode OP_CLEAR  = 2'd0;
    localparam t_opcode OP_APPEND = 2'd1;
    localparam t_opcode OP_ALLOC  = 2'd2;

    localparam t_status STAT_OK     = 2'd0;
    localparam t_status STAT_NO_FIT = 2'd1;
    localparam t_status STAT_FULL   = 2'd2;

    localparam t_fit_mode FIT_FIRST = 2'd0;
    localparam t_fit_mode FIT_BEST  = 2'd1;
    localparam t_fit_mode FIT_WORST = 2'd2;

    // Register index taken from the word address
    localparam logic CFG_IDX_FIT_MODE = 1'b0;

    typedef struct packed {
        t_opcode                 opcode;
        logic [ADDR_FIELD_W-1:0] hole_start;
        logic [ADDR_FIELD_W-1:0] hole_length;
        logic [REQ_W-1:0]        request_size;
        logic [PID_W-1:0]        process_id;
        logic [SID_W-1:0]        segment_id;
    } t_cmd;

    typedef struct packed {
        t_status                 status;
        logic [ADDR_FIELD_W-1:0] segment_base;
        logic [REQ_W-1:0]        segment_length;
        logic [PID_W-1:0]        owner_process;
        logic [SID_W-1:0]        owner_segment;
    } t_result;

    // Sequencer to fit unit control
    typedef struct packed {
        logic      clear;
        logic      check;
        t_fit_mode mode;
    } t_fit_ctl;

    // Fit unit status back to the sequencer
    typedef struct packed {
        logic found;
        logic exhausts;
    } t_fit_stat;

endpackage

@@ src/shac_hole_mem.sv @@
// Hole table storage: one write port, one read port with registered data.
// Entries hold {base, size}; no package dependency.
module shac_hole_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 48
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry, data registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/shac_fit_unit.sv @@
// Shared compare unit: weighs one table entry per cycle against the running pick
// and forms the advanced base and shrunk size. Depends on shac_pkg.
module shac_fit_unit #(
    parameter int ADDR_BITS = 24,
    parameter int IDX_W     = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  shac_pkg::t_fit_ctl       i_ctl,
    input  logic [IDX_W-1:0]         i_idx,
    input  logic [ADDR_BITS-1:0]     i_entry_base,
    input  logic [ADDR_BITS-1:0]     i_entry_size,
    input  logic [shac_pkg::REQ_W-1:0] i_req,
    output shac_pkg::t_fit_stat      o_stat,
    output logic [IDX_W-1:0]         o_pick_idx,
    output logic [ADDR_BITS-1:0]     o_pick_base,
    output logic [ADDR_BITS-1:0]     o_next_base,
    output logic [ADDR_BITS-1:0]     o_next_size
);

    import shac_pkg::*;

    localparam int CMP_W = (ADDR_BITS > REQ_W) ? ADDR_BITS : REQ_W;

    logic                 r_found;
    logic [IDX_W-1:0]     r_idx;
    logic [ADDR_BITS-1:0] r_base;
    logic [ADDR_BITS-1:0] r_size;
    logic [CMP_W-1:0]     w_sz;
    logic [CMP_W-1:0]     w_req;
    logic [ADDR_BITS-1:0] w_req_a;
    logic                 w_fits;
    logic                 w_take;

    assign w_sz    = CMP_W'(i_entry_size);
    assign w_req   = CMP_W'(i_req);
    assign w_req_a = ADDR_BITS'(i_req);
    assign w_fits  = (w_sz >= w_req);

    // Take the entry if adequate and preferred under the policy
    always_comb begin
        w_take = 1'b0;
        if (i_ctl.check && w_fits) begin
            if (!r_found) begin
                w_take = 1'b1;
            end else if (i_ctl.mode == FIT_BEST) begin
                w_take = (i_entry_size < r_size);
            end else if (i_ctl.mode == FIT_WORST) begin
                w_take = (i_entry_size > r_size);
            end
        end
    end

    // Hold the found flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    // Hold the picked entry
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_idx  <= i_idx;
            r_base <= i_entry_base;
            r_size <= i_entry_size;
        end
    end

    // Advance base, shrink size
    assign o_next_base     = r_base + w_req_a;
    assign o_next_size     = r_size - w_req_a;
    assign o_stat.found    = r_found;
    assign o_stat.exhausts = (o_next_size == '0);
    assign o_pick_idx      = r_idx;
    assign o_pick_base     = r_base;

endmodule

@@ src/segment_hole_allocator_core.sv @@
// Top level of the segment hole allocator: command port, register port,
// sequencer over the hole table and fit unit. Depends on shac_pkg and the assert header.
//
//   channel   handshake                          payload
//   command   start in, busy out                 i_cmd (t_cmd)
//   result    o_result_valid, one cycle          o_result (t_result)
//   config    psel/penable/pwrite, pready high   paddr, pwdata, prdata
//
// Clear, append and unknown commands finish in the accepting cycle; result next cycle.
// Allocate scans the table through the single memory read port, one entry a
// cycle, then shifts the later entries down when the chosen hole empties; an
// allocate on an empty table finishes in the accepting cycle.
// Synchronous active-low reset empties the table; entries need no clearing.
// The receiver cannot stall; busy is high while an allocate scans or shifts and
// drops in the cycle that strobes its result.
`include "segment_hole_allocator_core_assert.svh"

module segment_hole_allocator_core #(
    parameter int MAX_HOLES = 32,
    parameter int ADDR_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  shac_pkg::t_cmd                      i_cmd,
    output logic                                o_result_valid,
    output shac_pkg::t_result                   o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [shac_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [shac_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [shac_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import shac_pkg::*;

    localparam int AW = $clog2(MAX_HOLES);
    localparam int CW = $clog2(MAX_HOLES + 1);
    localparam int DW = 2 * ADDR_BITS;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_SHIFT = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_count, n_count;
    logic [REQ_W-1:0] r_req, n_req;
    logic             r_chk_vld, n_chk_vld;
    logic [AW-1:0]    r_chk_idx, n_chk_idx;
    logic             r_wb_vld, n_wb_vld;
    logic [AW-1:0]    r_wb_addr, n_wb_addr;
    t_fit_mode        r_fit_mode;
    t_result          r_res, n_res;
    logic             r_res_vld, n_res_vld;

    logic                 w_accept;
    logic                 w_alloc_go;
    logic                 w_cfg_wr;
    logic [ADDR_BITS-1:0] w_hstart;
    logic [ADDR_BITS-1:0] w_hlen;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [DW-1:0]        w_wr_data;
    logic                 w_rd_en;
    logic [AW-1:0]        w_rd_addr;
    logic [DW-1:0]        w_rd_data;
    t_fit_ctl             w_fit_ctl;
    t_fit_stat            w_fit_stat;
    logic [AW-1:0]        w_pick_idx;
    logic [ADDR_BITS-1:0] w_pick_base;
    logic [ADDR_BITS-1:0] w_next_base;
    logic [ADDR_BITS-1:0] w_next_size;

    assign busy       = (r_state != ST_IDLE);
    assign w_accept   = start && (r_state == ST_IDLE);
    assign w_alloc_go = w_accept && (i_cmd.opcode == OP_ALLOC) && (r_count != '0);
    assign w_hstart   = ADDR_BITS'(i_cmd.hole_start);
    assign w_hlen     = ADDR_BITS'(i_cmd.hole_length);

    // Register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[CFG_ADDR_W-1] == CFG_IDX_FIT_MODE);
    assign prdata   = (paddr[CFG_ADDR_W-1] == CFG_IDX_FIT_MODE)
                      ? CFG_DATA_W'(r_fit_mode) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= FIT_FIRST;
        end else if (w_cfg_wr) begin
            r_fit_mode <= pwdata[1:0];
        end
    end

    shac_hole_mem #(
        .DEPTH (MAX_HOLES),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    shac_fit_unit #(
        .ADDR_BITS (ADDR_BITS),
        .IDX_W     (AW)
    ) u_fit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_fit_ctl),
        .i_idx        (r_chk_idx),
        .i_entry_base (w_rd_data[DW-1:ADDR_BITS]),
        .i_entry_size (w_rd_data[ADDR_BITS-1:0]),
        .i_req        (r_req),
        .o_stat       (w_fit_stat),
        .o_pick_idx   (w_pick_idx),
        .o_pick_base  (w_pick_base),
        .o_next_base  (w_next_base),
        .o_next_size  (w_next_size)
    );

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_count   = r_count;
        n_req     = r_req;
        n_chk_vld = 1'b0;
        n_chk_idx = r_chk_idx;
        n_wb_vld  = 1'b0;
        n_wb_addr = r_wb_addr;
        n_res     = r_res;
        n_res_vld = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_wb_addr;
        w_wr_data = w_rd_data;
        w_rd_en   = 1'b0;
        w_rd_addr = r_idx[AW-1:0];
        w_fit_ctl.clear = 1'b0;
        w_fit_ctl.check = r_chk_vld;
        w_fit_ctl.mode  = r_fit_mode;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_req                = i_cmd.request_size;
                    n_res.status         = STAT_OK;
                    n_res.segment_base   = '0;
                    n_res.segment_length = '0;
                    n_res.owner_process  = i_cmd.process_id;
                    n_res.owner_segment  = i_cmd.segment_id;
                    case (i_cmd.opcode)
                        OP_CLEAR: begin
                            n_count   = '0;
                            n_res_vld = 1'b1;
                        end
                        OP_APPEND: begin
                            n_res_vld = 1'b1;
                            if (r_count >= CW'(MAX_HOLES)) begin
                                n_res.status = STAT_FULL;
                            end else if (w_hlen != '0) begin
                                w_wr_en   = 1'b1;
                                w_wr_addr = r_count[AW-1:0];
                                w_wr_data = {w_hstart, w_hlen};
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_ALLOC: begin
                            n_res.segment_length = i_cmd.request_size;
                            if (r_count == '0) begin
                                n_res.status = STAT_NO_FIT;
                                n_res_vld    = 1'b1;
                            end else begin
                                n_state         = ST_SCAN;
                                n_idx           = '0;
                                w_fit_ctl.clear = 1'b1;
                            end
                        end
                        default: begin
                            n_res_vld = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_idx < r_count) begin
                    // Issue the next entry to the fit unit
                    w_rd_en   = 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_idx[AW-1:0];
                    n_idx     = r_idx + CW'(1);
                end else if (!r_chk_vld) begin
                    // Scan drained: decide
                    n_state = ST_IDLE;
                    if (!w_fit_stat.found) begin
                        n_res.status = STAT_NO_FIT;
                        n_res_vld    = 1'b1;
                    end else begin
                        n_res.segment_base = ADDR_FIELD_W'(w_pick_base);
                        if (w_fit_stat.exhausts) begin
                            n_state = ST_SHIFT;
                            n_idx   = CW'(w_pick_idx) + CW'(1);
                        end else begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = w_pick_idx;
                            w_wr_data = {w_next_base, w_next_size};
                            n_res_vld = 1'b1;
                        end
                    end
                end
            end
            ST_SHIFT: begin
                // Drop the emptied hole: move each later entry down one place
                if (r_wb_vld) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_wb_addr;
                    w_wr_data = w_rd_data;
                end
                if (r_idx < r_count) begin
                    w_rd_en   = 1'b1;
                    n_wb_vld  = 1'b1;
                    n_wb_addr = r_idx[AW-1:0] - AW'(1);
                    n_idx     = r_idx + CW'(1);
                end else begin
                    n_count   = r_count - CW'(1);
                    n_res_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_count   <= '0;
            r_chk_vld <= 1'b0;
            r_wb_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_count   <= n_count;
            r_chk_vld <= n_chk_vld;
            r_wb_vld  <= n_wb_vld;
            r_res_vld <= n_res_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_chk_idx <= n_chk_idx;
        r_wb_addr <= n_wb_addr;
        r_res     <= n_res;
    end

    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

    `SHAC_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_HOLES))
    `SHAC_ASSERT_IMPL(a_shift_nonempty, i_clk, i_rst_n, r_state == ST_SHIFT, r_count != '0)
    `SHAC_ASSERT_IMPL(a_result_idle, i_clk, i_rst_n, r_res_vld, r_state == ST_IDLE)
    `SHAC_ASSERT_NEXT(a_alloc_scans, i_clk, i_rst_n, w_alloc_go, r_state == ST_SCAN)

endmodule

@@ tb/sv/segment_hole_allocator_core_test.sv @@
// Self-checking testbench for segment_hole_allocator_core: directed and random command
// sequences under all fit modes, predicted by a hole-table scoreboard.
// Depends on shac_pkg and the segment_hole_allocator_core RTL.
module segment_hole_allocator_core_test;

    import shac_pkg::*;

    // Scoreboard: own copy of the hole table, queue of results still due
    class hole_table_board;
        localparam int HOLE_SLOTS = 32;

        logic [ADDR_FIELD_W-1:0] base_tab [HOLE_SLOTS];
        logic [ADDR_FIELD_W-1:0] size_tab [HOLE_SLOTS];
        int unsigned             hole_cnt;
        t_fit_mode               mode;
        t_result                 due_results [$];
        int                      errors;
        int                      results_seen;
        int                      placed;
        int                      refused;
        int                      emptied;
        int                      full_hits;

        function new();
            hole_cnt     = 0;
            mode         = FIT_FIRST;
            errors       = 0;
            results_seen = 0;
            placed       = 0;
            refused      = 0;
            emptied      = 0;
            full_hits    = 0;
        endfunction

        function void set_mode(t_fit_mode m);
            mode = m;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Apply one accepted transaction to the table and queue its outcome
        function void note_command(t_cmd c);
            t_result r;
            int      pick;
            int      i;
            r               = '0;
            r.owner_process = c.process_id;
            r.owner_segment = c.segment_id;
            case (c.opcode)
                OP_CLEAR: begin
                    hole_cnt = 0;
                end
                OP_APPEND: begin
                    if (hole_cnt >= HOLE_SLOTS) begin
                        r.status = STAT_FULL;
                        full_hits++;
                    end else if (c.hole_length != '0) begin
                        base_tab[hole_cnt] = c.hole_start;
                        size_tab[hole_cnt] = c.hole_length;
                        hole_cnt++;
                    end
                end
                OP_ALLOC: begin
                    r.segment_length = c.request_size;
                    // scan in table order; ties keep the earliest hole
                    pick = -1;
                    for (i = 0; i < int'(hole_cnt); i++) begin
                        if (size_tab[i] < c.request_size) continue;
                        if (pick < 0) begin
                            pick = i;
                            if (mode != FIT_BEST && mode != FIT_WORST) break;
                        end else if (mode == FIT_BEST && size_tab[i] < size_tab[pick]) begin
                            pick = i;
                        end else if (mode == FIT_WORST && size_tab[i] > size_tab[pick]) begin
                            pick = i;
                        end
                    end
                    if (pick < 0) begin
                        r.status = STAT_NO_FIT;
                        refused++;
                    end else begin
                        r.segment_base = base_tab[pick];
                        base_tab[pick] = base_tab[pick] + c.request_size;
                        size_tab[pick] = size_tab[pick] - c.request_size;
                        placed++;
                        // drop an emptied hole and close the gap
                        if (size_tab[pick] == '0) begin
                            for (i = pick; i + 1 < int'(hole_cnt); i++) begin
                                base_tab[i] = base_tab[i + 1];
                                size_tab[i] = size_tab[i + 1];
                            end
                            hole_cnt--;
                            emptied++;
                        end
                    end
                end
                default: ;
            endcase
            due_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch: %s got %h want %h", what, got, want);
            errors++;
        endtask

        // Compare a result transaction with the oldest one due
        task check_result(t_result got);
            t_result want;
            results_seen++;
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(got.segment_base), 32'(0));
            end else begin
                want = due_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.segment_base != want.segment_base)
                    report_mismatch("segment_base", 32'(got.segment_base),
                                    32'(want.segment_base));
                if (got.segment_length != want.segment_length)
                    report_mismatch("segment_length", 32'(got.segment_length),
                                    32'(want.segment_length));
                if (got.owner_process != want.owner_process)
                    report_mismatch("owner_process", 32'(got.owner_process),
                                    32'(want.owner_process));
                if (got.owner_segment != want.owner_segment)
                    report_mismatch("owner_segment", 32'(got.owner_segment),
                                    32'(want.owner_segment));
            end
        endtask
    endclass

    localparam t_opcode   OP_NOP      = 2'd3;
    localparam t_fit_mode FIT_UNKNOWN = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] FIT_MODE_ADDR = '0;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int DRAIN_CYCLES    = 2 * 32 + 8;
    localparam t_fit_mode PHASE_MODES [8] = '{FIT_BEST, FIT_WORST, FIT_UNKNOWN, FIT_FIRST,
                                              FIT_WORST, FIT_BEST, FIT_FIRST, FIT_UNKNOWN};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_cmd                  i_cmd;
    logic                  o_result_valid;
    t_result               o_result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    hole_table_board board;
    int              items_sent;
    bit              quiet;

    segment_hole_allocator_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Clock, period 10
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Check every result transaction as it is strobed
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            board.check_result(o_result);
    end

    function automatic logic [23:0] rand24();
        return 24'($urandom());
    endfunction

    function automatic t_cmd make_cmd(t_opcode op, logic [23:0] hs, logic [23:0] hl,
                                      logic [23:0] req);
        t_cmd c;
        c.opcode       = op;
        c.hole_start   = hs;
        c.hole_length  = hl;
        c.request_size = req;
        c.process_id   = 16'($urandom());
        c.segment_id   = 8'($urandom());
        return c;
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long one
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        if (r < 19) return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    // Offer one command and hold it until the block takes it
    task automatic send_command(input t_cmd c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_command(c);
        items_sent++;
    endtask

    // Drop start and wait until every result due has arrived
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Register write: setup then access cycle, only while idle
    task automatic write_fit_mode(input t_fit_mode m);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FIT_MODE_ADDR;
        pwdata  <= 32'(m);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.set_mode(m);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One sequence: optional clear, a batch of appends, then allocations with occasional noise commands
    task automatic run_session();
        int          holes;
        int          allocs;
        int          k;
        int          r;
        logic [23:0] len;
        logic [23:0] req;
        logic [23:0] hs;
        quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) != 0)
            send_command(make_cmd(OP_CLEAR, rand24(), rand24(), rand24()));
        holes = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 10);
        for (k = 0; k < holes; k++) begin
            r = $urandom_range(0, 11);
            if (r == 0)      len = '0;
            else if (r == 1) len = rand24();
            else if (r == 2) len = '1;
            else             len = 24'($urandom_range(1, 64));
            // some bases near the top so that advancing wraps
            hs = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(24'hFFFF00, 24'hFFFFFF))
                                             : rand24();
            send_command(make_cmd(OP_APPEND, hs, len, rand24()));
        end
        allocs = $urandom_range(holes, 2 * holes + 4);
        for (k = 0; k < allocs; k++) begin
            if ($urandom_range(0, 11) == 0) begin
                // noise: any opcode, any fields
                send_command(make_cmd(t_opcode'($urandom_range(0, 3)), rand24(), rand24(),
                                      rand24()));
            end else begin
                r = $urandom_range(0, 9);
                if (r == 0)      req = '0;
                else if (r == 1) req = rand24();
                else             req = 24'($urandom_range(1, 48));
                send_command(make_cmd(OP_ALLOC, rand24(), rand24(), req));
            end
        end
    endtask

    // Run limit
    initial begin
        #8000000;
        $display("segment_hole_allocator_core regression: fail");
        $finish;
    end

    initial begin
        t_cmd c;
        int   p;
        int   phase_end;
        board      = new();
        items_sent = 0;
        quiet      = 1'b0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, ignored items, wrap, exact fits, each policy
        write_fit_mode(FIT_FIRST);
        c = make_cmd(OP_ALLOC, '0, '0, '0);
        c.process_id = '0;
        c.segment_id = '0;
        send_command(c);
        send_command(make_cmd(OP_ALLOC, '0, '0, '1));
        send_command(make_cmd(OP_APPEND, 24'h000100, '0, '0));
        c = make_cmd(OP_NOP, '1, '1, '1);
        c.process_id = '1;
        c.segment_id = '1;
        send_command(c);
        send_command(make_cmd(OP_APPEND, 24'hFFFFF0, 24'h000100, '0));
        send_command(make_cmd(OP_ALLOC, '0, '0, 24'h000020));
        send_command(make_cmd(OP_APPEND, 24'h001000, 24'h000040, '0));
        send_command(make_cmd(OP_APPEND, 24'h002000, 24'h000010, '0));
        send_command(make_cmd(OP_APPEND, 24'h003000, 24'h000040, '0));
        send_command(make_cmd(OP_ALLOC, '0, '0, '0));
        send_command(make_cmd(OP_ALLOC, '0, '0, 24'h0000E0));
        send_command(make_cmd(OP_ALLOC, '0, '0, 24'h000010));
        write_fit_mode(FIT_BEST);
        send_command(make_cmd(OP_ALLOC, '0, '0, 24'h000010));
        send_command(make_cmd(OP_ALLOC, '0, '0, 24'h000030));
        write_fit_mode(FIT_WORST);
        send_command(make_cmd(OP_APPEND, 24'h005000, 24'h000040, '0));
        send_command(make_cmd(OP_ALLOC, '0, '0, 24'h000008));
        send_command(make_cmd(OP_ALLOC, '0, '0, 24'h000041));
        write_fit_mode(FIT_UNKNOWN);
        send_command(make_cmd(OP_ALLOC, '0, '0, 24'h000038));
        send_command(make_cmd(OP_APPEND, '1, '1, '0));
        send_command(make_cmd(OP_ALLOC, '0, '0, '1));
        send_command(make_cmd(OP_CLEAR, rand24(), rand24(), rand24()));
        send_command(make_cmd(OP_ALLOC, '0, '0, 24'h000001));

        // Random phases, one fit mode each
        for (p = 0; p < 8; p++) begin
            write_fit_mode(PHASE_MODES[p]);
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) run_session();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d commands, %0d results, under first, best, worst and undefined fit",
                 items_sent, board.results_seen);
        $display("allocations placed %0d, refused %0d, holes emptied %0d, full-table appends %0d",
                 board.placed, board.refused, board.emptied, board.full_hits);
        if (board.errors == 0)
            $display("segment_hole_allocator_core regression: pass");
        else
            $display("segment_hole_allocator_core regression: fail");
        $finish;
    end

endmodule
